@@ design/ssp_pkg.sv @@
`default_nettype none

package ssp_pkg;

   // default widths of the byte total and the millisecond clock
   localparam int BYTE_BITS_DEF = 48;
   localparam int TIME_BITS_DEF = 32;

   localparam int TPUT_W    = 32;
   localparam int RUN_W     = 4;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   // Mbps = bytes * 8 / (ms * 1000) = bytes / (125 * ms)
   localparam int MS_PER_S      = 1000;
   localparam int BITS_PER_BYTE = 8;
   localparam int TPUT_DIVISOR  = MS_PER_S / BITS_PER_BYTE;
   localparam int TPUT_DIV_W    = 7;

   localparam logic [RUN_W-1:0] RUN_MAX = 4'd15;

   // register reset values
   localparam logic                  MODE_RST     = 1'b0;
   localparam logic [15:0]           TPUT_THR_RST = 16'd200;
   localparam logic signed [7:0]     RSSI_THR_RST = -8'sd60;
   localparam logic [RUN_W-1:0]      UP_RST       = 4'd2;
   localparam logic [RUN_W-1:0]      DOWN_RST     = 4'd5;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_POLICY_MODE    = 3'd0,
      CSR_TPUT_THRESHOLD = 3'd1,
      CSR_RSSI_THRESHOLD = 3'd2,
      CSR_UP_TICKS       = 3'd3,
      CSR_DOWN_TICKS     = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

   function automatic logic [RUN_W-1:0] run_inc(input logic [RUN_W-1:0] x);
      run_inc = (x < RUN_MAX) ? x + 1'b1 : RUN_MAX;
   endfunction

endpackage

`default_nettype wire

@@ design/ssp_div.sv @@
`default_nettype none

module ssp_div #(
   parameter int DVD_W = ssp_pkg::BYTE_BITS_DEF,
   parameter int DVS_W = ssp_pkg::TIME_BITS_DEF + ssp_pkg::TPUT_DIV_W
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [DVD_W-1:0]       dividend,
   input  wire logic [DVS_W-1:0]       divisor,
   output logic [DVD_W-1:0]            quotient,
   output ssp_pkg::div_status_type     status
);
   import ssp_pkg::*;

   // restoring divider, one quotient bit per cycle
   localparam int CNT_W = $clog2(DVD_W + 1);

   logic [DVD_W-1:0] dvd_ff;
   logic [DVS_W-1:0] dvs_ff;
   logic [DVS_W-1:0] rem_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             busy_ff;
   logic             done_ff;

   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             qbit;

   assign trial = {rem_ff, dvd_ff[DVD_W-1]};
   assign diff  = trial - {1'b0, dvs_ff};
   assign qbit  = (trial >= {1'b0, dvs_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         // one-cycle pulse after the last quotient bit
         done_ff <= !start && busy_ff && (cnt_ff == CNT_W'(1));
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNT_W'(DVD_W);
            dvd_ff  <= dividend;
            dvs_ff  <= divisor;
            rem_ff  <= '0;
         end else if (busy_ff) begin
            // remainder stays below divisor, so it fits DVS_W bits
            rem_ff <= qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
            dvd_ff <= {dvd_ff[DVD_W-2:0], qbit};
            cnt_ff <= cnt_ff - 1'b1;
            if (cnt_ff == CNT_W'(1)) begin
               busy_ff <= 1'b0;
            end
         end
      end
   end

   assign quotient    = dvd_ff;
   assign status.busy = busy_ff;
   assign status.done = done_ff;

endmodule

`default_nettype wire

@@ design/spatial_stream_switch_policy.sv @@
// Spatial stream switch policy: picks one or two spatial streams once per tick.
// Input channel (req_*): one word per tick with signal strength, running byte
//   total, millisecond time and coexistence flags. req_ready is high only while
//   the sequencer is idle; one word is worked on at a time.
// Result channel (rsp_*): one word per tick with the chosen mode, a change flag,
//   a sampled flag and the throughput in Mbps. The result sits in an output
//   register, so a stalled receiver only holds the block once the next tick's
//   result is ready as well.
// Config channel (csr_*): index and data, always ready; write only when idle.
// Divider: the throughput quotient comes from a restoring divider producing one
//   bit per cycle; it is needed only for a measured tick whose bytes and time
//   both grew. A new word can be accepted once the result is loaded into the
//   output register.
// Reset (synchronous, active high): registers to defaults, two streams, run
//   counters and previous sample cleared, no result pending.
`default_nettype none

module spatial_stream_switch_policy #(
   parameter int BYTE_BITS = ssp_pkg::BYTE_BITS_DEF,
   parameter int TIME_BITS = ssp_pkg::TIME_BITS_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // input channel
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic signed [7:0]             req_rssi,
   input  wire logic [BYTE_BITS-1:0]          req_total_bytes,
   input  wire logic [TIME_BITS-1:0]          req_time_ms,
   input  wire logic                          req_multi_connection,
   input  wire logic                          req_concurrency_mode_one,
   input  wire logic                          req_bt_connected,
   input  wire logic                          req_on_24ghz,
   // result channel
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic                               rsp_two_streams,
   output logic                               rsp_changed,
   output logic                               rsp_measured,
   output logic [ssp_pkg::TPUT_W-1:0]         rsp_throughput_mbps,
   // config channel
   input  wire logic                          csr_valid,
   output logic                               csr_ready,
   input  wire logic [ssp_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [ssp_pkg::CSR_DAT_W-1:0] csr_data
);
   import ssp_pkg::*;

   localparam int DVS_W = TIME_BITS + TPUT_DIV_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CHECK,
      ST_DIVIDE,
      ST_APPLY
   } state_type;

   state_type state_ff;

   // config registers
   logic                 mode_ff;
   logic [15:0]          tput_thr_ff;
   logic signed [7:0]    rssi_thr_ff;
   logic [RUN_W-1:0]     up_ticks_ff;
   logic [RUN_W-1:0]     down_ticks_ff;

   // policy state
   logic                 two_ff;
   logic [RUN_W-1:0]     low_run_ff;
   logic [RUN_W-1:0]     high_run_ff;
   logic [RUN_W-1:0]     weak_run_ff;
   logic [BYTE_BITS-1:0] prev_bytes_ff;
   logic [TIME_BITS-1:0] prev_time_ff;

   // latched tick
   logic signed [7:0]    rssi_ff;
   logic [BYTE_BITS-1:0] bytes_ff;
   logic [TIME_BITS-1:0] now_ff;
   logic                 multi_ff;
   logic                 conc_one_ff;
   logic                 bt_ff;
   logic                 band24_ff;
   logic [TPUT_W-1:0]    tput_ff;

   // output register
   logic                 rsp_valid_ff;
   logic                 rsp_two_ff;
   logic                 rsp_changed_ff;
   logic                 rsp_measured_ff;
   logic [TPUT_W-1:0]    rsp_tput_ff;

   // decision
   logic                 coex;
   logic                 weak_rssi;
   logic                 grew;
   logic                 out_free;
   logic                 out_load;
   logic                 two_in;
   logic [RUN_W-1:0]     low_run_in;
   logic [RUN_W-1:0]     high_run_in;
   logic [RUN_W-1:0]     weak_run_in;
   logic [RUN_W-1:0]     low_inc;
   logic [RUN_W-1:0]     high_inc;
   logic [RUN_W-1:0]     weak_inc;
   logic                 measured_in;

   // divider hookup
   logic                 div_start;
   logic [BYTE_BITS-1:0] delta_bytes;
   logic [TIME_BITS-1:0] delta_time;
   logic [DVS_W-1:0]     div_divisor;
   logic [BYTE_BITS-1:0] div_quot;
   div_status_type       div_status;
   logic                 quot_hi;
   logic [TPUT_W-1:0]    quot_sat;

   assign coex      = (multi_ff && !conc_one_ff) || (bt_ff && band24_ff);
   assign weak_rssi = (rssi_ff < rssi_thr_ff);
   assign grew      = (bytes_ff > prev_bytes_ff) && (now_ff > prev_time_ff);

   assign delta_bytes = bytes_ff - prev_bytes_ff;
   assign delta_time  = now_ff - prev_time_ff;
   // bytes / (125 * ms) equals bits per microsecond
   assign div_divisor = DVS_W'(delta_time) * DVS_W'(TPUT_DIVISOR);
   assign div_start   = (state_ff == ST_CHECK) && !mode_ff && !coex && !weak_rssi && grew;

   ssp_div #(
      .DVD_W (BYTE_BITS),
      .DVS_W (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (delta_bytes),
      .divisor  (div_divisor),
      .quotient (div_quot),
      .status   (div_status)
   );

   // quotient saturates at 32 bits
   assign quot_hi  = |(div_quot >> TPUT_W);
   assign quot_sat = quot_hi ? '1 : div_quot[TPUT_W-1:0];

   assign low_inc  = run_inc(low_run_ff);
   assign high_inc = run_inc(high_run_ff);
   assign weak_inc = run_inc(weak_run_ff);

   always_comb begin
      two_in      = two_ff;
      low_run_in  = low_run_ff;
      high_run_in = high_run_ff;
      weak_run_in = weak_run_ff;
      measured_in = 1'b0;
      if (mode_ff) begin
         // periodic: down_ticks in two streams, then up_ticks in one
         if (two_ff) begin
            low_run_in = low_inc;
            if (low_inc >= down_ticks_ff) begin
               two_in     = 1'b0;
               low_run_in = '0;
            end
         end else begin
            high_run_in = high_inc;
            if (high_inc >= up_ticks_ff) begin
               two_in      = 1'b1;
               high_run_in = '0;
            end
         end
      end else if (coex) begin
         low_run_in  = '0;
         high_run_in = '0;
         weak_run_in = '0;
         two_in      = 1'b1;
      end else if (weak_rssi) begin
         low_run_in  = '0;
         high_run_in = '0;
         weak_run_in = weak_inc;
         if (!two_ff && (weak_inc >= up_ticks_ff)) begin
            two_in      = 1'b1;
            weak_run_in = '0;
         end
      end else begin
         weak_run_in = '0;
         measured_in = 1'b1;
         if (tput_ff >= TPUT_W'(tput_thr_ff)) begin
            low_run_in = '0;
            if (!two_ff) begin
               high_run_in = high_inc;
               if (high_inc >= up_ticks_ff) begin
                  two_in      = 1'b1;
                  high_run_in = '0;
               end
            end
         end else begin
            high_run_in = '0;
            if (two_ff) begin
               low_run_in = low_inc;
               if (low_inc >= down_ticks_ff) begin
                  two_in     = 1'b0;
                  low_run_in = '0;
               end
            end
         end
      end
   end

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign out_load  = (state_ff == ST_APPLY) && out_free;
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         mode_ff       <= MODE_RST;
         tput_thr_ff   <= TPUT_THR_RST;
         rssi_thr_ff   <= RSSI_THR_RST;
         up_ticks_ff   <= UP_RST;
         down_ticks_ff <= DOWN_RST;
         two_ff        <= 1'b1;
         low_run_ff    <= '0;
         high_run_ff   <= '0;
         weak_run_ff   <= '0;
         prev_bytes_ff <= '0;
         prev_time_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid) begin
            case (csr_index)
               CSR_POLICY_MODE:    mode_ff       <= csr_data[0];
               CSR_TPUT_THRESHOLD: tput_thr_ff   <= csr_data;
               CSR_RSSI_THRESHOLD: rssi_thr_ff   <= csr_data[7:0];
               CSR_UP_TICKS:       up_ticks_ff   <= csr_data[RUN_W-1:0];
               CSR_DOWN_TICKS:     down_ticks_ff <= csr_data[RUN_W-1:0];
               default: ;
            endcase
         end

         // a new result replaces the one leaving in the same cycle
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  rssi_ff     <= req_rssi;
                  bytes_ff    <= req_total_bytes;
                  now_ff      <= req_time_ms;
                  multi_ff    <= req_multi_connection;
                  conc_one_ff <= req_concurrency_mode_one;
                  bt_ff       <= req_bt_connected;
                  band24_ff   <= req_on_24ghz;
                  state_ff    <= ST_CHECK;
               end
            end
            ST_CHECK: begin
               tput_ff <= '0;
               if (!mode_ff && !coex && !weak_rssi) begin
                  // sample point: always store current bytes and time
                  prev_bytes_ff <= bytes_ff;
                  prev_time_ff  <= now_ff;
               end
               state_ff <= div_start ? ST_DIVIDE : ST_APPLY;
            end
            ST_DIVIDE: begin
               if (div_status.done) begin
                  tput_ff  <= quot_sat;
                  state_ff <= ST_APPLY;
               end
            end
            ST_APPLY: begin
               if (out_free) begin
                  two_ff          <= two_in;
                  low_run_ff      <= low_run_in;
                  high_run_ff     <= high_run_in;
                  weak_run_ff     <= weak_run_in;
                  rsp_two_ff      <= two_in;
                  rsp_changed_ff  <= (two_in != two_ff);
                  rsp_measured_ff <= measured_in;
                  rsp_tput_ff     <= tput_ff;
                  state_ff        <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_two_streams     = rsp_two_ff;
   assign rsp_changed         = rsp_changed_ff;
   assign rsp_measured        = rsp_measured_ff;
   assign rsp_throughput_mbps = rsp_tput_ff;

endmodule

`default_nettype wire

@@ dv/spatial_stream_switch_policy_tb.sv @@
`timescale 1ns / 1ps

// Testbench for the spatial stream switch policy.
// A directed table opens the run, then phases of random ticks under several
// register settings (defaults, extremes, zero run lengths, random values).
// Every accepted tick is run through a local policy model; each result word
// is checked field by field against the oldest waiting choice.
module spatial_stream_switch_policy_tb;
   import ssp_pkg::*;

   localparam int BYTE_W         = BYTE_BITS_DEF;
   localparam int TIME_W         = TIME_BITS_DEF;
   localparam int PHASES         = 8;
   localparam int TICKS_PER_PH   = 55;
   // idle margin after the last result before the next phase
   localparam int SETTLE_CYCLES  = 64;
   localparam int WATCHDOG_LIMIT = 4000;

   // coexistence flag bits in table rows: {multi, conc_one, bt, 2.4 GHz}
   localparam logic [3:0] F_NONE  = 4'b0000;
   localparam logic [3:0] F_MULTI = 4'b1000;
   localparam logic [3:0] F_CONC  = 4'b0100;
   localparam logic [3:0] F_BT    = 4'b0010;
   localparam logic [3:0] F_BAND  = 4'b0001;

   localparam logic [47:0] BYTES_MAX = 48'hFFFF_FFFF_FFFF;
   localparam logic [31:0] TPUT_SAT  = 32'hFFFF_FFFF;

   typedef struct packed {
      logic [7:0]        rssi;
      logic [BYTE_W-1:0] bytes;
      logic [TIME_W-1:0] ms;
      logic              multi;
      logic              conc_one;
      logic              bt;
      logic              band24;
   } tick_type;

   typedef struct packed {
      logic              two;
      logic              changed;
      logic              measured;
      logic [TPUT_W-1:0] mbps;
   } choice_type;

   typedef struct packed {
      tick_type   tick;
      logic       typed;     // expectation read straight off the table
      choice_type choice;
   } dir_row_type;

   // ---------------------------------------------------------------------
   // DUT ports, inputs driven to known values from time zero
   // ---------------------------------------------------------------------
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [7:0]    req_rssi = '0;
   logic [BYTE_W-1:0]    req_total_bytes = '0;
   logic [TIME_W-1:0]    req_time_ms = '0;
   logic                 req_multi_connection = 1'b0;
   logic                 req_concurrency_mode_one = 1'b0;
   logic                 req_bt_connected = 1'b0;
   logic                 req_on_24ghz = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic                 rsp_two_streams;
   logic                 rsp_changed;
   logic                 rsp_measured;
   logic [TPUT_W-1:0]    rsp_throughput_mbps;
   logic                 csr_valid = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_data = '0;

   spatial_stream_switch_policy u_dut (
      .clock                    (clock),
      .reset                    (reset),
      .req_valid                (req_valid),
      .req_ready                (req_ready),
      .req_rssi                 (req_rssi),
      .req_total_bytes          (req_total_bytes),
      .req_time_ms              (req_time_ms),
      .req_multi_connection     (req_multi_connection),
      .req_concurrency_mode_one (req_concurrency_mode_one),
      .req_bt_connected         (req_bt_connected),
      .req_on_24ghz             (req_on_24ghz),
      .rsp_valid                (rsp_valid),
      .rsp_ready                (rsp_ready),
      .rsp_two_streams          (rsp_two_streams),
      .rsp_changed              (rsp_changed),
      .rsp_measured             (rsp_measured),
      .rsp_throughput_mbps      (rsp_throughput_mbps),
      .csr_valid                (csr_valid),
      .csr_ready                (csr_ready),
      .csr_index                (csr_index),
      .csr_data                 (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Policy model state and register shadow
   // ---------------------------------------------------------------------
   logic              cfg_mode;
   logic [15:0]       cfg_tput_thr;
   logic signed [7:0] cfg_rssi_thr;
   logic [RUN_W-1:0]  cfg_up;
   logic [RUN_W-1:0]  cfg_down;

   logic              pol_two;
   logic [RUN_W-1:0]  run_low;
   logic [RUN_W-1:0]  run_high;
   logic [RUN_W-1:0]  run_weak;
   logic [BYTE_W-1:0] last_bytes;
   logic [TIME_W-1:0] last_ms;

   choice_type pending_choices[$];
   int         errors = 0;

   // stream cursor for well-formed random ticks
   longint unsigned cur_bytes;
   logic [TIME_W-1:0] cur_ms;
   int burst_left = 0;

   function automatic logic [RUN_W-1:0] bump_run(logic [RUN_W-1:0] x);
      return (x == 4'd15) ? x : x + 4'd1;
   endfunction

   // Advances the model by one tick and returns the choice it reports.
   function automatic choice_type predict_choice(tick_type t);
      choice_type      c;
      logic            was_two;
      longint unsigned db;
      longint unsigned dm;
      longint unsigned q;
      was_two    = pol_two;
      c.measured = 1'b0;
      c.mbps     = '0;
      if (cfg_mode) begin
         // periodic: down_ticks in two streams, up_ticks in one
         if (pol_two) begin
            run_low = bump_run(run_low);
            if (run_low >= cfg_down) begin
               pol_two = 1'b0;
               run_low = '0;
            end
         end else begin
            run_high = bump_run(run_high);
            if (run_high >= cfg_up) begin
               pol_two  = 1'b1;
               run_high = '0;
            end
         end
      end else if ((t.multi && !t.conc_one) || (t.bt && t.band24)) begin
         // coexistence forces two streams and clears all runs
         run_low  = '0;
         run_high = '0;
         run_weak = '0;
         pol_two  = 1'b1;
      end else if ($signed(t.rssi) < $signed(cfg_rssi_thr)) begin
         run_low  = '0;
         run_high = '0;
         run_weak = bump_run(run_weak);
         if (!pol_two && run_weak >= cfg_up) begin
            pol_two  = 1'b1;
            run_weak = '0;
         end
      end else begin
         run_weak   = '0;
         c.measured = 1'b1;
         if (t.bytes > last_bytes && t.ms > last_ms) begin
            db = longint'(t.bytes) - longint'(last_bytes);
            dm = longint'(t.ms) - longint'(last_ms);
            q  = (db / TPUT_DIVISOR) / dm;
            c.mbps = (q > longint'(TPUT_SAT)) ? TPUT_SAT : q[31:0];
         end
         last_bytes = t.bytes;
         last_ms    = t.ms;
         if (c.mbps >= {16'd0, cfg_tput_thr}) begin
            run_low = '0;
            if (!pol_two) begin
               run_high = bump_run(run_high);
               if (run_high >= cfg_up) begin
                  pol_two  = 1'b1;
                  run_high = '0;
               end
            end
         end else begin
            run_high = '0;
            if (pol_two) begin
               run_low = bump_run(run_low);
               if (run_low >= cfg_down) begin
                  pol_two = 1'b0;
                  run_low = '0;
               end
            end
         end
      end
      c.two     = pol_two;
      c.changed = (pol_two != was_two);
      return c;
   endfunction

   function automatic dir_row_type mk_row(int rssi, logic [BYTE_W-1:0] bytes,
                                          logic [TIME_W-1:0] ms, logic [3:0] flags,
                                          logic typed, logic two, logic chg,
                                          logic meas, logic [TPUT_W-1:0] mbps);
      dir_row_type r;
      r.tick.rssi     = rssi[7:0];
      r.tick.bytes    = bytes;
      r.tick.ms       = ms;
      r.tick.multi    = flags[3];
      r.tick.conc_one = flags[2];
      r.tick.bt       = flags[1];
      r.tick.band24   = flags[0];
      r.typed         = typed;
      r.choice        = {two, chg, meas, mbps};
      return r;
   endfunction

   // Flags that never trigger coexistence; every flag bit still toggles.
   function automatic logic [3:0] quiet_flags();
      logic [3:0] f;
      f = 4'($urandom_range(0, 15));
      if (f[3]) f[2] = 1'b1;
      if (f[1]) f[0] = 1'b0;
      return f;
   endfunction

   // Random tick: mostly a growing byte/time stream with throughput
   // scattered around the threshold, plus coexistence, weak and noise words.
   function automatic tick_type next_random_tick();
      tick_type        t;
      int              kind;
      int              lo;
      int              target;
      int              dms;
      longint unsigned db;
      logic [3:0]      f;
      kind = $urandom_range(0, 99);
      lo   = cfg_rssi_thr;
      f    = quiet_flags();
      t.rssi = 8'(lo + $urandom_range(0, 127 - lo));
      if (kind < 8) begin
         f = 4'($urandom_range(0, 15));
         if ($urandom_range(0, 1)) f[3:2] = 2'b10;
         else                      f[1:0] = 2'b11;
         t.rssi = 8'($urandom_range(0, 255));
      end else if (kind < 22 && lo > -128) begin
         t.rssi = 8'(-128 + $urandom_range(0, lo + 127));
      end
      if (kind >= 22 && kind < 27) begin
         // noise: arbitrary stream position
         t.rssi = 8'($urandom_range(0, 255));
         f      = 4'($urandom_range(0, 15));
         t.bytes = {16'($urandom), $urandom};
         t.ms    = $urandom;
         if ($urandom_range(0, 1)) begin
            cur_bytes = t.bytes;
            cur_ms    = t.ms;
         end
      end else begin
         dms    = ($urandom_range(0, 19) == 0) ? 0 : $urandom_range(1, 2000);
         target = $urandom_range(0, 2 * int'(cfg_tput_thr) + 4);
         db     = longint'(target) * TPUT_DIVISOR * dms;
         if (dms > 0) db += $urandom_range(0, TPUT_DIVISOR * dms - 1);
         case ($urandom_range(0, 29))
            0: db = {$urandom_range(0, 255), $urandom};   // saturating burst
            1: db = 0;
            default: ;
         endcase
         cur_bytes = (cur_bytes + db) & longint'(BYTES_MAX);
         cur_ms    = cur_ms + TIME_W'(dms);
         t.bytes   = cur_bytes[BYTE_W-1:0];
         t.ms      = cur_ms;
      end
      {t.multi, t.conc_one, t.bt, t.band24} = f;
      return t;
   endfunction

   // Sender pacing: bursts of random length separated by random gaps.
   task automatic pace();
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
   endtask

   // Presents one tick word and holds it until accepted. Leaves valid high.
   task automatic drive_tick(tick_type t, logic typed, choice_type typed_choice);
      choice_type c;
      req_valid                <= 1'b1;
      req_rssi                 <= t.rssi;
      req_total_bytes          <= t.bytes;
      req_time_ms              <= t.ms;
      req_multi_connection     <= t.multi;
      req_concurrency_mode_one <= t.conc_one;
      req_bt_connected         <= t.bt;
      req_on_24ghz             <= t.band24;
      do @(posedge clock); while (!req_ready);
      c = predict_choice(t);
      pending_choices.push_back(typed ? typed_choice : c);
   endtask

   // Register write; leaves csr_valid high so writes can go back to back.
   task automatic csr_write(csr_index_type idx, logic [CSR_DAT_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_POLICY_MODE:    cfg_mode     = value[0];
         CSR_TPUT_THRESHOLD: cfg_tput_thr = value;
         CSR_RSSI_THRESHOLD: cfg_rssi_thr = value[7:0];
         CSR_UP_TICKS:       cfg_up       = value[RUN_W-1:0];
         CSR_DOWN_TICKS:     cfg_down     = value[RUN_W-1:0];
         default: ;
      endcase
   endtask

   task automatic apply_setting(logic mode, logic [15:0] thr, int rssi_thr,
                                logic [3:0] up, logic [3:0] down);
      csr_write(CSR_POLICY_MODE,    16'(mode));
      csr_write(CSR_TPUT_THRESHOLD, thr);
      csr_write(CSR_RSSI_THRESHOLD, {8'h00, rssi_thr[7:0]});
      csr_write(CSR_UP_TICKS,       16'(up));
      csr_write(CSR_DOWN_TICKS,     16'(down));
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Stop the sender, wait for every result, then let the block settle.
   task automatic drain();
      req_valid <= 1'b0;
      while (pending_choices.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Receiver: stall pattern that steps through four styles as its phase counter cycles
   // ---------------------------------------------------------------------
   logic [9:0] stall_phase = '0;

   always @(posedge clock) begin
      stall_phase <= stall_phase + 10'd1;
      case (stall_phase[9:8])
         2'd0: rsp_ready <= 1'b1;                          // no stalls
         2'd1: rsp_ready <= 1'($urandom_range(0, 1));
         2'd2: rsp_ready <= (stall_phase[3:0] < 4'd11);    // fixed stall window
         default: rsp_ready <= ($urandom_range(0, 3) == 0);
      endcase
   end

   // ---------------------------------------------------------------------
   // Result checker
   // ---------------------------------------------------------------------
   choice_type want;

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_choices.size() == 0) begin
            $display("%0t ERROR result word with no tick pending", $time);
            errors++;
         end else begin
            want = pending_choices.pop_front();
            if (rsp_two_streams !== want.two) begin
               $display("%0t ERROR two_streams expected %0d actual %0d",
                        $time, want.two, rsp_two_streams);
               errors++;
            end
            if (rsp_changed !== want.changed) begin
               $display("%0t ERROR changed expected %0d actual %0d",
                        $time, want.changed, rsp_changed);
               errors++;
            end
            if (rsp_measured !== want.measured) begin
               $display("%0t ERROR measured expected %0d actual %0d",
                        $time, want.measured, rsp_measured);
               errors++;
            end
            if (rsp_throughput_mbps !== want.mbps) begin
               $display("%0t ERROR throughput_mbps expected %0d actual %0d",
                        $time, want.mbps, rsp_throughput_mbps);
               errors++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Watchdog: too many cycles with no word moving on any channel
   // ---------------------------------------------------------------------
   int quiet_cycles = 0;

   initial begin
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
             (csr_valid && csr_ready))
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Regression FAIL");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   dir_row_type dir_rows[$];

   initial begin
      cfg_mode     = MODE_RST;
      cfg_tput_thr = TPUT_THR_RST;
      cfg_rssi_thr = RSSI_THR_RST;
      cfg_up       = UP_RST;
      cfg_down     = DOWN_RST;
      pol_two      = 1'b1;
      run_low      = '0;
      run_high     = '0;
      run_weak     = '0;
      last_bytes   = '0;
      last_ms      = '0;

      // after reset: two streams, defaults 200 Mbps / -60 dBm / up 2 / down 5
      // coexistence through either term, even with a weak signal
      dir_rows.push_back(mk_row(0, 0, 0, F_MULTI, 1, 1, 0, 0, 0));
      dir_rows.push_back(mk_row(-128, 0, 0, F_BT | F_BAND, 1, 1, 0, 0, 0));
      // rssi at the threshold is not weak; nothing grew so throughput is 0
      dir_rows.push_back(mk_row(-60, 0, 0, F_MULTI | F_CONC | F_BT, 1, 1, 0, 1, 0));
      // full byte swing over 1 ms saturates the quotient
      dir_rows.push_back(mk_row(127, BYTES_MAX, 1, F_NONE, 1, 1, 0, 1, TPUT_SAT));
      // weak signal while in two streams only counts
      dir_rows.push_back(mk_row(-61, 0, 0, F_NONE, 1, 1, 0, 0, 0));
      // bytes flat, then bytes wrapped: both give zero throughput
      dir_rows.push_back(mk_row(0, BYTES_MAX, 1001, F_NONE, 1, 1, 0, 1, 0));
      dir_rows.push_back(mk_row(0, 0, 2001, F_NONE, 1, 1, 0, 1, 0));
      // low readings, the last one below threshold by one, switch down
      dir_rows.push_back(mk_row(-20, 6250000, 3001, F_NONE, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(-20, 31125000, 4001, F_NONE, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(-20, 56000000, 5001, F_NONE, 0, 0, 0, 0, 0));
      // coexistence from one stream forces up
      dir_rows.push_back(mk_row(-20, 0, 0, F_BT | F_BAND, 0, 0, 0, 0, 0));
      // five flat ticks switch down again
      for (int i = 0; i < 5; i++)
         dir_rows.push_back(mk_row(-40, 56000000, 6001 + 1000 * i, F_NONE,
                                   0, 0, 0, 0, 0));
      // exactly at threshold counts high, then weak run switches up
      dir_rows.push_back(mk_row(-40, 81000000, 11001, F_NONE, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(-100, 0, 0, F_NONE, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(-128, 0, 0, F_NONE, 0, 0, 0, 0, 0));
      // time went backward, then a huge time step
      dir_rows.push_back(mk_row(5, 81000125, 0, F_NONE, 0, 0, 0, 0, 0));
      dir_rows.push_back(mk_row(5, 81001125, 32'hFFFF_FFFF, F_NONE, 0, 0, 0, 0, 0));

      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         pace();
         drive_tick(dir_rows[i].tick, dir_rows[i].typed, dir_rows[i].choice);
      end
      drain();

      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: ;                                         // keep defaults
            1: apply_setting(1'b1, 16'd200, -60, 4'd1, 4'd15);
            2: apply_setting(1'b0, 16'd0, -128, 4'd15, 4'd1);
            3: apply_setting(1'b0, 16'hFFFF, 0, 4'd1, 4'd15);
            4: apply_setting(1'b1, 16'd65, -56, 4'd0, 4'd0);  // zero acts as one
            5: apply_setting(1'b0, 16'd0, -128, 4'd0, 4'd0);
            default:
               apply_setting(($urandom_range(0, 3) == 0),
                             16'($urandom_range(0, 1000)),
                             -$urandom_range(0, 128),
                             4'($urandom_range(1, 15)),
                             4'($urandom_range(1, 15)));
         endcase
         cur_bytes  = {16'($urandom), $urandom};
         cur_ms     = $urandom;
         burst_left = 0;
         for (int n = 0; n < TICKS_PER_PH; n++) begin
            pace();
            drive_tick(next_random_tick(), 1'b0, '0);
         end
         drain();
      end

      if (errors == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
